// File: src/qle_pkg.sv
// shared types, constants and helpers of the q-learning engine
`timescale 1ns / 1ps
package qle_pkg;

  localparam int Q_W      = 32;
  localparam int ACT_W    = 2;
  localparam int RATE_W   = 16;
  localparam int COORD_W  = 7;
  localparam int REWARD_W = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [RATE_W-1:0] LEARN_RATE_RST   = 16'd19661;
  localparam logic [RATE_W-1:0] DISCOUNT_RST     = 16'd19661;
  localparam logic [RATE_W-1:0] EXPLORE_RATE_RST = 16'd26214;

  localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXPLORE_RATE = 2'd2;

  // one table row: the four action values of a state
  typedef logic [3:0][Q_W-1:0] row_t;

  typedef struct packed {
    logic ld_max;   // capture best value of the next state
    logic ld_old;   // capture old value, start gamma product
    logic ld_diff;  // form target minus old
    logic ld_prod;  // alpha product
  } upd_ctrl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHOOSE,
    ST_UP_NEXT,
    ST_UP_CUR,
    ST_UP_TGT,
    ST_UP_MUL,
    ST_UP_WB
  } state_e;

  // lowest action index among the maxima
  function automatic logic [ACT_W-1:0] first_max(row_t r);
    logic [ACT_W-1:0] best;
    best = '0;
    for (int a = 1; a < 4; a++) begin
      if ($signed(r[a]) > $signed(r[best])) begin
        best = ACT_W'(a);
      end
    end
    return best;
  endfunction

endpackage

// File: src/tabular_q_learning_engine.sv
// top level of the tabular q-learning engine with epsilon-greedy choice
`timescale 1ns / 1ps
// Q table engine: each state (dx, dy), clamped to [-COORD_SPAN, COORD_SPAN-1], owns one
// row of four signed Q values in a single row-wide memory with registered read. A word
// with tuser = 0 chooses an action (random action when explore_draw < explore_rate,
// else the first maximum of the row); tuser = 1 applies the Q-learning update to
// taken_action and writes the row back. Every input word yields one output word.
// A choose word does one row read, then selects; an update word reads the next
// row, then the current row, through the one read port and passes the two
// registered multiplies of the update pipeline. The next word is taken once the
// current one has finished, even while its result still waits on the output register.
// After reset the block zeroes the table one row a cycle, all (2*COORD_SPAN)^2 rows
// (16384 at the default), and takes no input words meanwhile; configuration writes
// are taken at any time but belong in idle periods.
module tabular_q_learning_engine
  import qle_pkg::*;
#(
  parameter int COORD_SPAN = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input words
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // state_dx[6:0] state_dy[13:7] taken_action[15:14] reward[23:16]
  // next_dx[30:24] next_dy[37:31] explore_draw[53:38] random_action[55:54]
  input  logic [55:0]          s_axis_tdata,
  // kind[0]
  input  logic [0:0]           s_axis_tuser,
  // result words
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // chosen_action[1:0] q_value[33:2], zero fill [39:34]
  output logic [39:0]          m_axis_tdata,
  // explored[0]
  output logic [0:0]           m_axis_tuser,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [RATE_W-1:0]    cfg_data_i
);

  localparam int ROWS = 4 * COORD_SPAN * COORD_SPAN;
  localparam int RW   = $clog2(ROWS);

  // configuration registers
  logic [RATE_W-1:0] learn_rate_q, discount_q, explore_rate_q;

  // control state
  state_e        state_q, state_d;
  logic [RW-1:0] clr_cnt_q;
  logic          m_valid_q;

  // latched item
  logic [RW-1:0]               cur_row_q;
  logic [ACT_W-1:0]            taken_q, rnd_q;
  logic                        explore_q;
  logic signed [REWARD_W-1:0]  reward_q;
  row_t                        row_q;

  // result register
  logic [ACT_W-1:0] m_action_q;
  logic             m_explored_q;
  logic [Q_W-1:0]   m_qval_q;

  // unpacked input fields
  logic                       in_kind;
  logic signed [COORD_W-1:0]  in_dx, in_dy, in_ndx, in_ndy;
  logic [ACT_W-1:0]           in_taken, in_rnd;
  logic signed [REWARD_W-1:0] in_reward;
  logic [RATE_W-1:0]          in_draw;
  logic [RW-1:0]              in_cur_row, in_next_row;

  // memory and datapath
  logic          rd_en, wr_en;
  logic [RW-1:0] rd_addr, wr_addr;
  row_t          rd_row, wr_row;
  logic [ACT_W-1:0]      fmax;
  logic signed [Q_W-1:0] new_q;
  upd_ctrl_t     ctrl;
  logic          in_acc, out_free, out_load;
  logic [ACT_W-1:0] res_action;
  logic          res_explored;
  logic [Q_W-1:0] res_q;

  assign in_kind   = s_axis_tuser[0];
  assign in_dx     = s_axis_tdata[6:0];
  assign in_dy     = s_axis_tdata[13:7];
  assign in_taken  = s_axis_tdata[15:14];
  assign in_reward = s_axis_tdata[23:16];
  assign in_ndx    = s_axis_tdata[30:24];
  assign in_ndy    = s_axis_tdata[37:31];
  assign in_draw   = s_axis_tdata[53:38];
  assign in_rnd    = s_axis_tdata[55:54];

  qle_row_addr #(.COORD_SPAN(COORD_SPAN)) u_cur_addr (
    .dx_i  (in_dx),
    .dy_i  (in_dy),
    .row_o (in_cur_row)
  );

  qle_row_addr #(.COORD_SPAN(COORD_SPAN)) u_next_addr (
    .dx_i  (in_ndx),
    .dy_i  (in_ndy),
    .row_o (in_next_row)
  );

  // row-wide table: one read and one write per cycle
  qle_ram #(.WIDTH($bits(row_t)), .DEPTH(ROWS)) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_row),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_row)
  );

  assign fmax = first_max(rd_row);

  qle_update #(.FRAC_BITS(FRAC_BITS)) u_update (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .max_next_i   (rd_row[fmax]),
    .old_i        (rd_row[taken_q]),
    .reward_i     (reward_q),
    .learn_rate_i (learn_rate_q),
    .discount_i   (discount_q),
    .new_q_o      (new_q)
  );

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  // sequencer: next state, memory access and pipeline strobes
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = cur_row_q;
    wr_en         = 1'b0;
    wr_addr       = cur_row_q;
    wr_row        = row_q;
    wr_row[taken_q] = new_q;
    ctrl          = '0;
    out_load      = 1'b0;
    res_action    = taken_q;
    res_explored  = 1'b0;
    res_q         = new_q;
    case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_q;
        wr_row  = '0;
        if (clr_cnt_q == RW'(ROWS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          rd_en   = 1'b1;
          // update reads the next state's row first
          rd_addr = in_kind ? in_next_row : in_cur_row;
          state_d = in_kind ? ST_UP_NEXT : ST_CHOOSE;
        end
      end
      ST_CHOOSE: begin
        res_action   = explore_q ? rnd_q : fmax;
        res_explored = explore_q;
        res_q        = rd_row[res_action];
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_UP_NEXT: begin
        ctrl.ld_max = 1'b1;
        rd_en       = 1'b1;
        state_d     = ST_UP_CUR;
      end
      ST_UP_CUR: begin
        ctrl.ld_old = 1'b1;
        state_d     = ST_UP_TGT;
      end
      ST_UP_TGT: begin
        ctrl.ld_diff = 1'b1;
        state_d      = ST_UP_MUL;
      end
      ST_UP_MUL: begin
        ctrl.ld_prod = 1'b1;
        state_d      = ST_UP_WB;
      end
      ST_UP_WB: begin
        // write back and post the result together
        if (out_free) begin
          wr_en    = 1'b1;
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_cnt_q      <= '0;
      m_valid_q      <= 1'b0;
      learn_rate_q   <= LEARN_RATE_RST;
      discount_q     <= DISCOUNT_RST;
      explore_rate_q <= EXPLORE_RATE_RST;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + RW'(1);
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_LEARN_RATE:   learn_rate_q   <= cfg_data_i;
          REG_DISCOUNT:     discount_q     <= cfg_data_i;
          REG_EXPLORE_RATE: explore_rate_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_row_q <= in_cur_row;
      taken_q   <= in_taken;
      rnd_q     <= in_rnd;
      reward_q  <= in_reward;
      explore_q <= (in_draw < explore_rate_q);
    end
    if (ctrl.ld_old) begin
      row_q <= rd_row;  // keep the other three actions for write-back
    end
    if (out_load) begin
      m_action_q   <= res_action;
      m_explored_q <= res_explored;
      m_qval_q     <= res_q;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, m_qval_q, m_action_q};
  assign m_axis_tuser  = m_explored_q;

endmodule

// File: src/qle_ram.sv
// generic single-port-write, registered-read memory
`timescale 1ns / 1ps
module qle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/qle_row_addr.sv
// clamps a signed offset pair to the table and forms its row address
`timescale 1ns / 1ps
module qle_row_addr
  import qle_pkg::*;
#(
  parameter int COORD_SPAN = 64
) (
  input  logic signed [COORD_W-1:0]                  dx_i,
  input  logic signed [COORD_W-1:0]                  dy_i,
  output logic [$clog2(4*COORD_SPAN*COORD_SPAN)-1:0] row_o
);

  localparam int SIDE = 2 * COORD_SPAN;
  localparam int RW   = $clog2(SIDE * SIDE);
  localparam int CW   = $clog2(SIDE);
  localparam logic signed [9:0] LO = -10'(COORD_SPAN);
  localparam logic signed [9:0] HI = 10'(COORD_SPAN - 1);
  localparam logic signed [9:0] OFS = 10'(COORD_SPAN);

  logic signed [9:0] x_ext, y_ext, x_clip, y_clip;
  logic [CW-1:0]     x_bin, y_bin;

  always_comb begin
    x_ext = 10'(dx_i);
    y_ext = 10'(dy_i);
    x_clip = (x_ext < LO) ? LO : ((x_ext > HI) ? HI : x_ext);
    y_clip = (y_ext < LO) ? LO : ((y_ext > HI) ? HI : y_ext);
    x_bin = CW'(x_clip + OFS);
    y_bin = CW'(y_clip + OFS);
    row_o = RW'(x_bin) * RW'(SIDE) + RW'(y_bin);
  end

endmodule

// File: src/qle_update.sv
// fixed-point q update pipeline: gamma product, difference, alpha product, saturate
`timescale 1ns / 1ps
module qle_update
  import qle_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  upd_ctrl_t                  ctrl_i,
  input  logic signed [Q_W-1:0]      max_next_i,
  input  logic signed [Q_W-1:0]      old_i,
  input  logic signed [REWARD_W-1:0] reward_i,
  input  logic [RATE_W-1:0]          learn_rate_i,
  input  logic [RATE_W-1:0]          discount_i,
  output logic signed [Q_W-1:0]      new_q_o
);

  localparam logic signed [38:0] Q_MAX = 39'sd2147483647;
  localparam logic signed [38:0] Q_MIN = -39'sd2147483648;

  logic signed [Q_W-1:0] max_q, old_q;
  logic signed [48:0]    gprod_q;
  logic signed [35:0]    diff_q;
  logic signed [52:0]    aprod_q;

  logic signed [16:0] disc_s, alpha_s;
  logic signed [48:0] gprod_d;
  logic signed [33:0] gterm, rscaled;
  logic signed [34:0] target;
  logic signed [35:0] diff_d;
  logic signed [52:0] aprod_d;
  logic signed [37:0] aterm;
  logic signed [38:0] sum;

  always_comb begin
    disc_s  = {1'b0, discount_i};
    alpha_s = {1'b0, learn_rate_i};
    gprod_d = disc_s * max_q;
    // round to nearest, ties upward: add half then floor shift
    gterm   = 34'((gprod_q + 49'sd32768) >>> 16);
    rscaled = 34'(reward_i) <<< FRAC_BITS;
    target  = 35'(rscaled) + 35'(gterm);
    diff_d  = 36'(target) - 36'(old_q);
    aprod_d = alpha_s * diff_q;
    aterm   = 38'((aprod_q + 53'sd32768) >>> 16);
    sum     = 39'(old_q) + 39'(aterm);
    if (sum > Q_MAX) begin
      new_q_o = Q_MAX[Q_W-1:0];
    end else if (sum < Q_MIN) begin
      new_q_o = Q_MIN[Q_W-1:0];
    end else begin
      new_q_o = sum[Q_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_max) begin
      max_q <= max_next_i;
    end
    if (ctrl_i.ld_old) begin
      old_q   <= old_i;
      gprod_q <= gprod_d;
    end
    if (ctrl_i.ld_diff) begin
      diff_q <= diff_d;
    end
    if (ctrl_i.ld_prod) begin
      aprod_q <= aprod_d;
    end
  end

endmodule
